>>> rtl/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types, codes and helpers of the ASCII hex frame decoder.
// ----------------------------------------------------------------------------
package afd_pkg;

    // Configuration register indexes
    localparam logic REG_OWN_ADDRESS    = 1'b0;
    localparam logic REG_REQUEST_HEADER = 1'b1;

    // Register reset values
    localparam logic [7:0] OWN_ADDRESS_RESET    = 8'h01;
    localparam logic [7:0] REQUEST_HEADER_RESET = 8'h3A;

    // Broadcast address byte
    localparam logic [7:0] BROADCAST_BYTE = 8'hFF;

    // Shortest well-formed frame in characters
    localparam logic [2:0] MIN_FRAME_CHARS = 3'd5;
    localparam logic [2:0] MAX_CHAR_COUNT  = 3'd7;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Data byte counter codes
    localparam logic [1:0] BIDX_NONE  = 2'd0;
    localparam logic [1:0] BIDX_FIRST = 2'd1;
    localparam logic [1:0] BIDX_MORE  = 2'd2;

    // Error flag bit positions
    localparam int ERR_HEADER  = 0;
    localparam int ERR_PAYLOAD = 1;
    localparam int ERR_BCAST   = 2;

    typedef enum logic [2:0] {
        VERDICT_OK_ADDRESSED  = 3'd0,
        VERDICT_OK_BROADCAST  = 3'd1,
        VERDICT_BAD_HEADER    = 3'd2,
        VERDICT_BAD_CK_CHAR   = 3'd3,
        VERDICT_CK_MISMATCH   = 3'd4,
        VERDICT_BAD_PAYLOAD   = 3'd5,
        VERDICT_ADDR_MISMATCH = 3'd6,
        VERDICT_TOO_SHORT     = 3'd7
    } verdict_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] verdict;
        logic       last_of_run;
    } afd_result_t;

    // Results produced by one accepted character
    typedef struct packed {
        logic [1:0]             num;
        afd_result_t [1:0]      item;
    } afd_push_t;

    // Decode one hex character: {valid, value}; invalid reads as 15
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c inside {[8'h30:8'h39]}) begin
                r = {1'b1, 4'(c - 8'h30)};
            end else if (c inside {[8'h41:8'h46]}) begin
                r = {1'b1, 4'(c - 8'h37)};
            end else if (c inside {[8'h61:8'h66]}) begin
                r = {1'b1, 4'(c - 8'h57)};
            end else begin
                r = {1'b0, 4'hF};
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/afd_frame_core.sv
// ----------------------------------------------------------------------------
// afd_frame_core
// Frame state, hex pair decode, checksum and verdict for one character per
// cycle while accept is high; hands up to two results per character to the result queue.
// ----------------------------------------------------------------------------
module afd_frame_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         char_in,
    input  logic               frame_end,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output afd_pkg::afd_push_t push
);
    import afd_pkg::*;

    logic [7:0] own_addr_reg;
    logic [7:0] header_reg;

    logic [7:0] d0_reg, d0_next;
    logic [7:0] d1_reg, d1_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] sum_reg, sum_next;
    logic       phase_reg, phase_next;
    logic [1:0] bidx_reg, bidx_next;
    logic [7:0] held_reg, held_next;
    logic [2:0] err_reg, err_next;

    logic [4:0] hi_dec, lo_dec, ck_hi_dec, ck_lo_dec;
    logic [7:0] pair_byte, ck_byte, first_byte;
    logic       pair_ok, ck_ok;
    verdict_t   verdict;
    afd_push_t  push_c;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg <= OWN_ADDRESS_RESET;
            header_reg   <= REQUEST_HEADER_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_OWN_ADDRESS:    own_addr_reg <= cfg_data;
                REG_REQUEST_HEADER: header_reg   <= cfg_data;
                default:            own_addr_reg <= own_addr_reg;
            endcase
        end
    end

    // Decode the held payload pair and the checksum pair
    assign hi_dec    = hex_decode(d1_reg);
    assign lo_dec    = hex_decode(d0_reg);
    assign pair_byte = {hi_dec[3:0], lo_dec[3:0]};
    assign pair_ok   = hi_dec[4] & lo_dec[4];
    assign ck_hi_dec = hex_decode(d0_reg);
    assign ck_lo_dec = hex_decode(char_in);
    assign ck_byte   = {ck_hi_dec[3:0], ck_lo_dec[3:0]};
    assign ck_ok     = ck_hi_dec[4] & ck_lo_dec[4];

    // Replace byte 0 by own address on broadcast
    assign first_byte = (held_reg != own_addr_reg && held_reg == BROADCAST_BYTE &&
                         pair_byte == BROADCAST_BYTE) ? own_addr_reg : held_reg;

    // Next frame state and results of this character
    always_comb begin
        err_next   = err_reg;
        phase_next = phase_reg;
        bidx_next  = bidx_reg;
        held_next  = held_reg;
        verdict    = VERDICT_ADDR_MISMATCH;
        push_c     = '0;

        if (cnt_reg == 3'd0) begin
            if (char_in != header_reg) begin
                err_next[ERR_HEADER] = 1'b1;
            end
        end else if (!frame_end && cnt_reg >= 3'd2) begin
            if (!phase_reg) begin
                phase_next = 1'b1;
            end else begin
                phase_next = 1'b0;
                if (!pair_ok) begin
                    err_next[ERR_PAYLOAD] = 1'b1;
                end
                case (bidx_reg)
                    BIDX_NONE: begin
                        held_next = pair_byte;
                        bidx_next = BIDX_FIRST;
                    end
                    BIDX_FIRST: begin
                        if (pair_byte == BROADCAST_BYTE) begin
                            err_next[ERR_BCAST] = 1'b1;
                        end
                        push_c.item[0].kind      = KIND_DATA;
                        push_c.item[0].data_byte = first_byte;
                        push_c.item[1].kind      = KIND_DATA;
                        push_c.item[1].data_byte = pair_byte;
                        push_c.num               = 2'd2;
                        bidx_next                = BIDX_MORE;
                    end
                    default: begin
                        push_c.item[0].kind      = KIND_DATA;
                        push_c.item[0].data_byte = pair_byte;
                        push_c.num               = 2'd1;
                    end
                endcase
            end
        end

        // Shift the delay line and accumulate the checksum
        sum_next = (cnt_reg >= 3'd2) ? sum_reg + d1_reg : sum_reg;
        d1_next  = d0_reg;
        d0_next  = char_in;
        cnt_next = (cnt_reg < MAX_CHAR_COUNT) ? cnt_reg + 3'd1 : cnt_reg;

        if (frame_end) begin
            if (err_next[ERR_HEADER]) begin
                verdict = VERDICT_BAD_HEADER;
            end else if (cnt_next < MIN_FRAME_CHARS) begin
                verdict = VERDICT_TOO_SHORT;
            end else if (!ck_ok) begin
                verdict = VERDICT_BAD_CK_CHAR;
            end else if (ck_byte != sum_next) begin
                verdict = VERDICT_CK_MISMATCH;
            end else if (err_next[ERR_PAYLOAD]) begin
                verdict = VERDICT_BAD_PAYLOAD;
            end else if (held_reg == own_addr_reg) begin
                verdict = VERDICT_OK_ADDRESSED;
            end else if (bidx_reg == BIDX_MORE && held_reg == BROADCAST_BYTE &&
                         err_next[ERR_BCAST]) begin
                verdict = VERDICT_OK_BROADCAST;
            end else begin
                verdict = VERDICT_ADDR_MISMATCH;
            end

            // Flush a lone first byte ahead of the status
            if (bidx_reg == BIDX_FIRST) begin
                push_c.item[0].kind      = KIND_DATA;
                push_c.item[0].data_byte = held_reg;
                push_c.item[1].kind      = KIND_STATUS;
                push_c.item[1].verdict   = verdict;
                push_c.num               = 2'd2;
            end else begin
                push_c.item[0].kind      = KIND_STATUS;
                push_c.item[0].verdict   = verdict;
                push_c.num               = 2'd1;
            end

            // Clear the frame
            err_next   = '0;
            phase_next = 1'b0;
            bidx_next  = BIDX_NONE;
            held_next  = '0;
            sum_next   = '0;
            d0_next    = '0;
            d1_next    = '0;
            cnt_next   = '0;
        end

        // Mark the last result of the run
        if (push_c.num == 2'd2) begin
            push_c.item[1].last_of_run = 1'b1;
        end else if (push_c.num == 2'd1) begin
            push_c.item[0].last_of_run = 1'b1;
        end
    end

    assign push = accept ? push_c : '0;

    // Frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_reg    <= '0;
            d1_reg    <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            phase_reg <= 1'b0;
            bidx_reg  <= BIDX_NONE;
            held_reg  <= '0;
            err_reg   <= '0;
        end else if (accept) begin
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            phase_reg <= phase_next;
            bidx_reg  <= bidx_next;
            held_reg  <= held_next;
            err_reg   <= err_next;
        end
    end

    // Frame end clears the frame state
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && frame_end |=> cnt_reg == 3'd0 && sum_reg == 8'd0 && bidx_reg == BIDX_NONE)
        else $error("frame state not cleared after frame end");

    // Byte counter saturates at two
    a_bidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bidx_reg != 2'd3)
        else $error("byte counter out of range");

    // An accepted frame-end character always yields a status result
    a_end_status: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && frame_end |-> push.num != 2'd0 &&
            (push.item[0].kind == KIND_STATUS || push.item[1].kind == KIND_STATUS))
        else $error("frame end without status result");

endmodule

>>> rtl/afd_result_fifo.sv
// ----------------------------------------------------------------------------
// afd_result_fifo
// Four-entry result queue; per cycle takes up to two, pops one on m_ready.
// ----------------------------------------------------------------------------
module afd_result_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  afd_pkg::afd_push_t   push,
    output logic                 space_ok,
    output logic                 m_valid,
    input  logic                 m_ready,
    output afd_pkg::afd_result_t head
);
    import afd_pkg::*;

    afd_result_t mem [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = count_reg != 3'd0;
    assign space_ok = count_reg <= 3'd2;
    assign head     = mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.num;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push.num} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the results of this cycle
    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem[wr_ptr_reg] <= push.item[0];
        end
        if (push.num == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= push.item[1];
        end
    end

    // Occupancy never exceeds the depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    // Results arrive only when two slots are free
    a_push_space: assert property (@(posedge aclk) disable iff (!aresetn)
        push.num != 2'd0 |-> count_reg <= 3'd2)
        else $error("push into full result queue");

    // A lone pop drops occupancy by one
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && push.num == 2'd0 |=> count_reg == $past(count_reg) - 3'd1)
        else $error("result queue count slip");

endmodule

>>> rtl/ascii_hex_frame_decoder.sv
// ----------------------------------------------------------------------------
// ascii_hex_frame_decoder
// Decodes an ASCII hex request frame into data bytes and a status verdict.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel s_*: one frame character per transaction, s_frame_end set
//   on the final character. The first character must match request_header.
// - Result channel m_*: data bytes (m_kind 0) and one status (m_kind 1) per
//   frame; m_last_of_run marks the last result caused by one character.
// - Config channel cfg_*: index 0 own_address, 1 request_header; always
//   ready; the user must write only while the block is idle (not enforced).
// - Results of a character are written to the result queue as it is taken.
// - Throughput: one character per cycle, bounded by the result port, which
//   delivers one result per cycle from a four-entry result queue.
// - s_ready is high while the queue has two free slots, so a stall on m_ready
//   backs up into s_ready once three or four results are queued.
// - Reset (aresetn low, synchronous) clears the frame state and the queue and
//   loads own_address 1 and request_header 0x3A.
// ----------------------------------------------------------------------------
module ascii_hex_frame_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_frame_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_data_byte,
    output logic [2:0] m_verdict,
    output logic       m_last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    import afd_pkg::*;

    afd_push_t   push;
    afd_result_t head;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Frame decode and state
    afd_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .char_in   (s_char_in),
        .frame_end (s_frame_end),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    // Result queue
    afd_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    assign m_kind        = head.kind;
    assign m_data_byte   = head.data_byte;
    assign m_verdict     = head.verdict;
    assign m_last_of_run = head.last_of_run;

endmodule
